// ===== rtl/core/tun_pkg.sv =====
// Package for the triangle unit normal block: widths, stage counts and payload types.
`default_nettype none

package tun_pkg;

   localparam int COORD_BITS       = 16;
   localparam int NORMAL_FRAC_BITS = 14;
   localparam int NORMAL_BITS      = NORMAL_FRAC_BITS + 2;

   // The largest normalised magnitude sits in [2^NORM_TOP, 2^(NORM_TOP+1)).
   localparam int NORM_TOP   = 29;

   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * DIFF_BITS;
   localparam int CROSS_BITS = PROD_BITS + 1;
   localparam int POS_BITS   = $clog2(CROSS_BITS);
   localparam int SHIFT_BITS = 8;

   localparam int NMAG_BITS  = NORM_TOP + 1;
   localparam int SQ_BITS    = 2 * NMAG_BITS;
   localparam int SUMSQ_BITS = SQ_BITS + 2;

   // Square root: one result bit per stage, trial bit walks down from the top even bit.
   localparam int ROOT_STEPS = SUMSQ_BITS / 2 + 1;
   localparam int ROOT_BITS  = SUMSQ_BITS + 1;
   localparam int LEN_BITS   = NMAG_BITS + 1;
   localparam int DEN_BITS   = LEN_BITS + 1;

   // Divide: one quotient bit per stage.
   localparam int QUO_BITS   = NORMAL_FRAC_BITS + 1;
   localparam int NUM_BITS   = NMAG_BITS + NORMAL_FRAC_BITS + 2;
   localparam int REM_BITS   = NUM_BITS + 1;

   typedef logic signed [COORD_BITS-1:0]  coord_type;
   typedef logic signed [NORMAL_BITS-1:0] normal_type;

endpackage : tun_pkg

`default_nettype wire

// ===== rtl/core/triangle_unit_normal.sv =====
// Top level of the triangle unit normal pipeline: cross product, square root and divide.
`default_nettype none

// channel   direction  handshake             payload
// req_      in         req_valid/req_ready   a, b, c corners (x, y, z), signed
// rsp_      out        rsp_valid/rsp_ready   normal x, y, z (signed Q1.14), degenerate
//
// One request per cycle while the pipe is not held; the depth is set mostly by the
// bit-per-stage square root and the bit-per-stage divider.
// Every stage advances together: the whole pipe holds only when the output register is
// full and rsp_ready is low, so nothing is dropped or repeated on a stall.
// Reset (synchronous, active high) clears the valid bits only; payload is not reset.

module triangle_unit_normal (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire tun_pkg::coord_type  req_a_x,
   input  wire tun_pkg::coord_type  req_a_y,
   input  wire tun_pkg::coord_type  req_a_z,
   input  wire tun_pkg::coord_type  req_b_x,
   input  wire tun_pkg::coord_type  req_b_y,
   input  wire tun_pkg::coord_type  req_b_z,
   input  wire tun_pkg::coord_type  req_c_x,
   input  wire tun_pkg::coord_type  req_c_y,
   input  wire tun_pkg::coord_type  req_c_z,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output tun_pkg::normal_type      rsp_normal_x,
   output tun_pkg::normal_type      rsp_normal_y,
   output tun_pkg::normal_type      rsp_normal_z,
   output logic                     rsp_degenerate
);
   import tun_pkg::*;

   logic adv;

   // ---------------------------------------------------------------- stage 1: edges
   logic signed [DIFF_BITS-1:0] diff_in [6];
   logic signed [DIFF_BITS-1:0] diff_ff [6];
   logic                        v1_ff, v1_in;

   // ---------------------------------------------------------------- stage 2: products
   logic signed [PROD_BITS-1:0] prod_in [6];
   logic signed [PROD_BITS-1:0] prod_ff [6];
   logic                        v2_ff;

   // ---------------------------------------------------------------- stage 3: cross
   logic signed [CROSS_BITS-1:0] cross_in [3];
   logic signed [CROSS_BITS-1:0] cross_ff [3];
   logic                         v3_ff;

   // ---------------------------------------------------------------- stage 4: magnitudes
   logic [CROSS_BITS-1:0] mag4_in [3];
   logic [CROSS_BITS-1:0] mag4_ff [3];
   logic [2:0]            neg4_in, neg4_ff;
   logic                  v4_ff;

   // ---------------------------------------------------------------- stage 5: maximum
   logic [CROSS_BITS-1:0] mag5_ff [3];
   logic [CROSS_BITS-1:0] max5_in, max5_ff;
   logic [2:0]            neg5_ff;
   logic                  deg5_in, deg5_ff;
   logic                  v5_ff;

   // ---------------------------------------------------------------- stage 6: leading one
   logic [CROSS_BITS-1:0] mag6_ff [3];
   logic [POS_BITS-1:0]   pos6_in, pos6_ff;
   logic [2:0]            neg6_ff;
   logic                  deg6_ff;
   logic                  v6_ff;

   // ---------------------------------------------------------------- stage 7: normalise
   logic [SHIFT_BITS-1:0] shl7, shr7;
   logic                  right7;
   logic [NMAG_BITS-1:0]  nmag7_in [3];
   logic [NMAG_BITS-1:0]  nmag7_ff [3];
   logic [2:0]            neg7_ff;
   logic                  deg7_ff;
   logic                  v7_ff;

   // ---------------------------------------------------------------- stage 8: squares
   logic [SQ_BITS-1:0]    sq8_in [3];
   logic [SQ_BITS-1:0]    sq8_ff [3];
   logic [NMAG_BITS-1:0]  nmag8_ff [3];
   logic [2:0]            neg8_ff;
   logic                  deg8_ff;
   logic                  v8_ff;

   // ---------------------------------------------------------------- stage 9: sum
   logic [SUMSQ_BITS-1:0] sum9_in, sum9_ff;
   logic [NMAG_BITS-1:0]  nmag9_ff [3];
   logic [2:0]            neg9_ff;
   logic                  deg9_ff;
   logic                  v9_ff;

   // ---------------------------------------------------------------- square root stages
   logic [ROOT_BITS-1:0]  rrem_ff [ROOT_STEPS];
   logic [ROOT_BITS-1:0]  rres_ff [ROOT_STEPS];
   logic [NMAG_BITS-1:0]  rmag_ff [ROOT_STEPS][3];
   logic [2:0]            rneg_ff [ROOT_STEPS];
   logic                  rdeg_ff [ROOT_STEPS];
   logic                  rval_ff [ROOT_STEPS];

   // ---------------------------------------------------------------- divide set-up
   logic [NUM_BITS-1:0]   num_in [3];
   logic [NUM_BITS-1:0]   num_ff [3];
   logic [LEN_BITS-1:0]   len_p;
   logic [DEN_BITS-1:0]   den_in, den_ff;
   logic [2:0]            pneg_ff;
   logic                  pdeg_ff;
   logic                  pval_ff;

   // ---------------------------------------------------------------- divide stages
   logic [REM_BITS-1:0]   drem_ff [QUO_BITS][3];
   logic [QUO_BITS-1:0]   dquo_ff [QUO_BITS][3];
   logic [DEN_BITS-1:0]   dden_ff [QUO_BITS];
   logic [2:0]            dneg_ff [QUO_BITS];
   logic                  ddeg_ff [QUO_BITS];
   logic                  dval_ff [QUO_BITS];

   // ---------------------------------------------------------------- output register
   normal_type            nrm_in [3];
   normal_type            nrm_ff [3];
   logic                  deg_out_ff;
   logic                  rsp_valid_ff;

   // Advance the whole pipe unless a finished result is still waiting to be taken.
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign v1_in     = req_valid;

   // Edge vectors d1 = b - a, d2 = c - a, sign-extended by one bit.
   always_comb begin
      diff_in[0] = DIFF_BITS'(req_b_x) - DIFF_BITS'(req_a_x);
      diff_in[1] = DIFF_BITS'(req_b_y) - DIFF_BITS'(req_a_y);
      diff_in[2] = DIFF_BITS'(req_b_z) - DIFF_BITS'(req_a_z);
      diff_in[3] = DIFF_BITS'(req_c_x) - DIFF_BITS'(req_a_x);
      diff_in[4] = DIFF_BITS'(req_c_y) - DIFF_BITS'(req_a_y);
      diff_in[5] = DIFF_BITS'(req_c_z) - DIFF_BITS'(req_a_z);
   end

   // Six partial products of the cross product, in pairs per component.
   always_comb begin
      prod_in[0] = PROD_BITS'(diff_ff[1]) * PROD_BITS'(diff_ff[5]);
      prod_in[1] = PROD_BITS'(diff_ff[2]) * PROD_BITS'(diff_ff[4]);
      prod_in[2] = PROD_BITS'(diff_ff[2]) * PROD_BITS'(diff_ff[3]);
      prod_in[3] = PROD_BITS'(diff_ff[0]) * PROD_BITS'(diff_ff[5]);
      prod_in[4] = PROD_BITS'(diff_ff[0]) * PROD_BITS'(diff_ff[4]);
      prod_in[5] = PROD_BITS'(diff_ff[1]) * PROD_BITS'(diff_ff[3]);
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cross_in[i] = CROSS_BITS'(prod_ff[2*i]) - CROSS_BITS'(prod_ff[2*i+1]);
         neg4_in[i]  = cross_ff[i][CROSS_BITS-1];
         mag4_in[i]  = neg4_in[i] ? CROSS_BITS'(-cross_ff[i]) : CROSS_BITS'(cross_ff[i]);
      end
   end

   // Largest magnitude; a zero maximum means a degenerate triangle.
   always_comb begin
      max5_in = mag4_ff[0];
      if (mag4_ff[1] > max5_in) begin
         max5_in = mag4_ff[1];
      end
      if (mag4_ff[2] > max5_in) begin
         max5_in = mag4_ff[2];
      end
      deg5_in = (max5_in == '0);
   end

   // Position of the leading one of the maximum.
   always_comb begin
      pos6_in = '0;
      for (int b = 0; b < CROSS_BITS; b++) begin
         if (max5_ff[b]) begin
            pos6_in = POS_BITS'(b);
         end
      end
   end

   // Bring the maximum into [2^NORM_TOP, 2^(NORM_TOP+1)); a right shift truncates.
   always_comb begin
      right7 = SHIFT_BITS'(pos6_ff) > SHIFT_BITS'(NORM_TOP);
      shl7   = SHIFT_BITS'(NORM_TOP) - SHIFT_BITS'(pos6_ff);
      shr7   = SHIFT_BITS'(pos6_ff) - SHIFT_BITS'(NORM_TOP);
      for (int i = 0; i < 3; i++) begin
         if (right7) begin
            nmag7_in[i] = NMAG_BITS'(mag6_ff[i] >> shr7);
         end else begin
            nmag7_in[i] = NMAG_BITS'((NMAG_BITS + CROSS_BITS)'(mag6_ff[i]) << shl7);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq8_in[i] = SQ_BITS'(nmag7_ff[i]) * SQ_BITS'(nmag7_ff[i]);
      end
      sum9_in = SUMSQ_BITS'(sq8_ff[0]) + SUMSQ_BITS'(sq8_ff[1]) + SUMSQ_BITS'(sq8_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
         v9_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= v1_in;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
         v9_ff <= v8_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         diff_ff  <= diff_in;
         prod_ff  <= prod_in;
         cross_ff <= cross_in;
         mag4_ff  <= mag4_in;
         neg4_ff  <= neg4_in;
         mag5_ff  <= mag4_ff;
         max5_ff  <= max5_in;
         neg5_ff  <= neg4_ff;
         deg5_ff  <= deg5_in;
         mag6_ff  <= mag5_ff;
         pos6_ff  <= pos6_in;
         neg6_ff  <= neg5_ff;
         deg6_ff  <= deg5_ff;
         nmag7_ff <= nmag7_in;
         neg7_ff  <= neg6_ff;
         deg7_ff  <= deg6_ff;
         sq8_ff   <= sq8_in;
         nmag8_ff <= nmag7_ff;
         neg8_ff  <= neg7_ff;
         deg8_ff  <= deg7_ff;
         sum9_ff  <= sum9_in;
         nmag9_ff <= nmag8_ff;
         neg9_ff  <= neg8_ff;
         deg9_ff  <= deg8_ff;
      end
   end

   // Digit-by-digit square root, one result bit per stage; trial bit 4^(ROOT_STEPS-1-j).
   for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_root
      logic [ROOT_BITS-1:0] rem_src, res_src, trial, rrem_in, rres_in;
      logic [ROOT_BITS-1:0] bit_val;
      logic [NMAG_BITS-1:0] mag_src [3];
      logic [2:0]           neg_src;
      logic                 deg_src, val_src;

      if (j == 0) begin : g_first
         assign rem_src = ROOT_BITS'(sum9_ff);
         assign res_src = '0;
         assign mag_src = nmag9_ff;
         assign neg_src = neg9_ff;
         assign deg_src = deg9_ff;
         assign val_src = v9_ff;
      end else begin : g_next
         assign rem_src = rrem_ff[j-1];
         assign res_src = rres_ff[j-1];
         assign mag_src = rmag_ff[j-1];
         assign neg_src = rneg_ff[j-1];
         assign deg_src = rdeg_ff[j-1];
         assign val_src = rval_ff[j-1];
      end

      assign bit_val = ROOT_BITS'(1) << (2 * (ROOT_STEPS - 1 - j));

      always_comb begin
         trial = res_src + bit_val;
         if (rem_src >= trial) begin
            rrem_in = rem_src - trial;
            rres_in = (res_src >> 1) + bit_val;
         end else begin
            rrem_in = rem_src;
            rres_in = res_src >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            rval_ff[j] <= 1'b0;
         end else if (adv) begin
            rval_ff[j] <= val_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rrem_ff[j] <= rrem_in;
            rres_ff[j] <= rres_in;
            rmag_ff[j] <= mag_src;
            rneg_ff[j] <= neg_src;
            rdeg_ff[j] <= deg_src;
         end
      end
   end

   // Set up the rounded divide: q = floor((2*mag*2^F + L) / (2*L)).
   always_comb begin
      len_p  = LEN_BITS'(rres_ff[ROOT_STEPS-1]);
      den_in = {len_p, 1'b0};
      for (int i = 0; i < 3; i++) begin
         num_in[i] = (NUM_BITS'(rmag_ff[ROOT_STEPS-1][i]) << (NORMAL_FRAC_BITS + 1))
                   + NUM_BITS'(len_p);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pval_ff <= 1'b0;
      end else if (adv) begin
         pval_ff <= rval_ff[ROOT_STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         num_ff  <= num_in;
         den_ff  <= den_in;
         pneg_ff <= rneg_ff[ROOT_STEPS-1];
         pdeg_ff <= rdeg_ff[ROOT_STEPS-1];
      end
   end

   // Restoring divide, one quotient bit per stage, three lanes sharing the divisor.
   for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
      logic [REM_BITS-1:0] rem_src [3];
      logic [QUO_BITS-1:0] quo_src [3];
      logic [REM_BITS-1:0] drem_in [3];
      logic [QUO_BITS-1:0] dquo_in [3];
      logic [REM_BITS-1:0] sub_val;
      logic [DEN_BITS-1:0] den_src;
      logic [2:0]          neg_src;
      logic                deg_src, val_src;

      if (k == 0) begin : g_first
         for (genvar i = 0; i < 3; i++) begin : g_lane
            assign rem_src[i] = REM_BITS'(num_ff[i]);
            assign quo_src[i] = '0;
         end
         assign den_src = den_ff;
         assign neg_src = pneg_ff;
         assign deg_src = pdeg_ff;
         assign val_src = pval_ff;
      end else begin : g_next
         assign rem_src = drem_ff[k-1];
         assign quo_src = dquo_ff[k-1];
         assign den_src = dden_ff[k-1];
         assign neg_src = dneg_ff[k-1];
         assign deg_src = ddeg_ff[k-1];
         assign val_src = dval_ff[k-1];
      end

      assign sub_val = REM_BITS'(den_src) << (QUO_BITS - 1 - k);

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            dquo_in[i] = quo_src[i];
            if (rem_src[i] >= sub_val) begin
               drem_in[i]                 = rem_src[i] - sub_val;
               dquo_in[i][QUO_BITS-1-k]   = 1'b1;
            end else begin
               drem_in[i] = rem_src[i];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dval_ff[k] <= 1'b0;
         end else if (adv) begin
            dval_ff[k] <= val_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            drem_ff[k] <= drem_in;
            dquo_ff[k] <= dquo_in;
            dden_ff[k] <= den_src;
            dneg_ff[k] <= neg_src;
            ddeg_ff[k] <= deg_src;
         end
      end
   end

   // Apply signs; drop the quotient of a degenerate triangle and return zeros.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (ddeg_ff[QUO_BITS-1]) begin
            nrm_in[i] = '0;
         end else if (dneg_ff[QUO_BITS-1][i]) begin
            nrm_in[i] = -NORMAL_BITS'(dquo_ff[QUO_BITS-1][i]);
         end else begin
            nrm_in[i] = NORMAL_BITS'(dquo_ff[QUO_BITS-1][i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dval_ff[QUO_BITS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nrm_ff     <= nrm_in;
         deg_out_ff <= ddeg_ff[QUO_BITS-1];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_normal_x   = nrm_ff[0];
   assign rsp_normal_y   = nrm_ff[1];
   assign rsp_normal_z   = nrm_ff[2];
   assign rsp_degenerate = deg_out_ff;

endmodule : triangle_unit_normal

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the triangle unit normal pipeline.
`default_nettype none

module testbench;
   import tun_pkg::*;

   localparam int N_RANDOM     = 700;
   localparam int WATCHDOG_MAX = 20000;
   localparam int DRAIN_CYCLES = 80;

   typedef struct packed {
      coord_type ax, ay, az, bx, by, bz, cx, cy, cz;
   } triangle_t;

   typedef struct packed {
      normal_type nx, ny, nz;
      logic       degen;
   } normal_t;

   // Directed row: corners, and whether a typed-in answer applies.
   typedef struct {
      triangle_t corners;
      bit        known;
      normal_t   answer;
   } stim_row_t;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   coord_type  req_a_x = '0, req_a_y = '0, req_a_z = '0;
   coord_type  req_b_x = '0, req_b_y = '0, req_b_z = '0;
   coord_type  req_c_x = '0, req_c_y = '0, req_c_z = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   normal_type rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic       rsp_degenerate;

   normal_t   normal_queue[$];
   int        mismatches = 0;
   int        accepted_reqs = 0;
   int        checked_rsps = 0;
   int        degen_rsps = 0;
   int        idle_cycles = 0;
   int        send_idle_pct = 9;
   int        recv_idle_pct = 52;

   triangle_unit_normal i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_a_x        (req_a_x),
      .req_a_y        (req_a_y),
      .req_a_z        (req_a_z),
      .req_b_x        (req_b_x),
      .req_b_y        (req_b_y),
      .req_b_z        (req_b_z),
      .req_c_x        (req_c_x),
      .req_c_y        (req_c_y),
      .req_c_z        (req_c_z),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_normal_x   (rsp_normal_x),
      .rsp_normal_y   (rsp_normal_y),
      .rsp_normal_z   (rsp_normal_z),
      .rsp_degenerate (rsp_degenerate)
   );

   always #1 clock = ~clock;

   // Bit-exact integer square root, floor of sqrt(v).
   function automatic logic [63:0] floor_sqrt(logic [63:0] v);
      logic [63:0] root;
      logic [63:0] bitpos;
      root   = '0;
      bitpos = 64'd1 << 62;
      while (bitpos > v) bitpos = bitpos >> 2;
      while (bitpos != 0) begin
         if (v >= root + bitpos) begin
            v    = v - (root + bitpos);
            root = (root >> 1) + bitpos;
         end else begin
            root = root >> 1;
         end
         bitpos = bitpos >> 2;
      end
      return root;
   endfunction

   // Exact cross product, normalise the largest magnitude into [2^29, 2^30), round-divide.
   function automatic normal_t face_normal(triangle_t t);
      logic signed [63:0] d1[3], d2[3], cr[3];
      logic [63:0]        mag[3];
      bit                 neg[3];
      logic [63:0]        top, sumsq, len, num, q;
      int                 msb;
      normal_t            r;
      d1[0] = 64'(t.bx) - 64'(t.ax);
      d1[1] = 64'(t.by) - 64'(t.ay);
      d1[2] = 64'(t.bz) - 64'(t.az);
      d2[0] = 64'(t.cx) - 64'(t.ax);
      d2[1] = 64'(t.cy) - 64'(t.ay);
      d2[2] = 64'(t.cz) - 64'(t.az);
      cr[0] = d1[1] * d2[2] - d1[2] * d2[1];
      cr[1] = d1[2] * d2[0] - d1[0] * d2[2];
      cr[2] = d1[0] * d2[1] - d1[1] * d2[0];
      top = '0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = cr[i] < 0;
         mag[i] = neg[i] ? -cr[i] : cr[i];
         if (mag[i] > top) top = mag[i];
      end
      r = '0;
      if (top == 0) begin
         r.degen = 1'b1;
         return r;
      end
      msb = 0;
      while (msb < 63 && (top >> (msb + 1)) != 0) msb++;
      sumsq = '0;
      for (int i = 0; i < 3; i++) begin
         if (msb > NORM_TOP) mag[i] = mag[i] >> (msb - NORM_TOP);
         else mag[i] = mag[i] << (NORM_TOP - msb);
         sumsq = sumsq + mag[i] * mag[i];
      end
      len = floor_sqrt(sumsq);
      for (int i = 0; i < 3; i++) begin
         num = (mag[i] << NORMAL_FRAC_BITS) << 1;
         q   = (num + len) / (len << 1);
         if (neg[i]) q = -q;
         case (i)
            0: r.nx = q[NORMAL_BITS-1:0];
            1: r.ny = q[NORMAL_BITS-1:0];
            default: r.nz = q[NORMAL_BITS-1:0];
         endcase
      end
      return r;
   endfunction

   function automatic triangle_t make_tri(int ax, int ay, int az, int bx, int by, int bz,
                                          int cx, int cy, int cz);
      triangle_t t;
      t.ax = coord_type'(ax); t.ay = coord_type'(ay); t.az = coord_type'(az);
      t.bx = coord_type'(bx); t.by = coord_type'(by); t.bz = coord_type'(bz);
      t.cx = coord_type'(cx); t.cy = coord_type'(cy); t.cz = coord_type'(cz);
      return t;
   endfunction

   function automatic normal_t make_normal(int nx, int ny, int nz, bit d);
      normal_t n;
      n.nx = normal_type'(nx); n.ny = normal_type'(ny); n.nz = normal_type'(nz);
      n.degen = d;
      return n;
   endfunction

   // Full-range, small or extreme coordinates; rand_tri picks full range half the time.
   function automatic coord_type rand_coord(int mode);
      case (mode)
         0: return coord_type'($urandom);
         1: return coord_type'($urandom_range(0, 64) - 32);
         2: return $urandom_range(0, 1) ? coord_type'(16'h7fff) : coord_type'(16'h8000);
         default: return coord_type'($urandom_range(0, 2048) - 1024);
      endcase
   endfunction

   function automatic triangle_t rand_tri();
      triangle_t t;
      int        mode;
      int        k;
      mode = $urandom_range(0, 9);
      mode = (mode < 5) ? 0 : (mode < 7) ? 3 : (mode < 9) ? 1 : 2;
      t = {rand_coord(mode), rand_coord(mode), rand_coord(mode),
           rand_coord(mode), rand_coord(mode), rand_coord(mode),
           rand_coord(mode), rand_coord(mode), rand_coord(mode)};
      // Force a degenerate triangle now and then: third corner on top of another one.
      if ($urandom_range(0, 19) == 0) begin
         k = int'($urandom_range(0, 1));
         t.cx = (k != 0) ? t.bx : t.ax;
         t.cy = (k != 0) ? t.by : t.ay;
         t.cz = (k != 0) ? t.bz : t.az;
      end
      return t;
   endfunction

   // Present one request and hold it until accepted; record the predicted normal.
   // Valid stays high straight into the next request unless the sender idles.
   task automatic send_request(triangle_t t, bit known, normal_t answer);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_a_x <= t.ax; req_a_y <= t.ay; req_a_z <= t.az;
      req_b_x <= t.bx; req_b_y <= t.by; req_b_z <= t.bz;
      req_c_x <= t.cx; req_c_y <= t.cy; req_c_z <= t.cz;
      normal_queue.push_back(known ? answer : face_normal(t));
      do @(posedge clock); while (!req_ready);
      accepted_reqs++;
   endtask

   // Receiver: randomly withhold ready, check each accepted response in order.
   always @(posedge clock) begin
      normal_t got, want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_normal_x, rsp_normal_y, rsp_normal_z, rsp_degenerate};
            if (normal_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("Unexpected response %h", got);
            end else begin
               want = normal_queue.pop_front();
               checked_rsps++;
               if (got.degen) degen_rsps++;
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Mismatch: expected x=%0d y=%0d z=%0d d=%b, got x=%0d y=%0d z=%0d d=%b",
                              want.nx, want.ny, want.nz, want.degen,
                              got.nx, got.ny, got.nz, got.degen);
               end
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         // Watchdog: count cycles with no handshake on either side.
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_MAX) begin
         $display("Watchdog expired with %0d responses outstanding", normal_queue.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   stim_row_t directed[$];

   initial begin
      stim_row_t row;
      // Coincident, collinear, axis-aligned and extreme corners.
      directed.push_back('{make_tri(0,0,0, 0,0,0, 0,0,0), 1, make_normal(0,0,0,1)});
      directed.push_back('{make_tri(5,5,5, 5,5,5, 5,5,5), 1, make_normal(0,0,0,1)});
      directed.push_back('{make_tri(0,0,0, 1,1,1, 2,2,2), 1, make_normal(0,0,0,1)});
      directed.push_back('{make_tri(-32768,-32768,-32768, 32767,32767,32767,
                                    -32768,-32768,-32768), 1, make_normal(0,0,0,1)});
      directed.push_back('{make_tri(0,0,0, 1,0,0, 0,1,0), 1, make_normal(0,0,16384,0)});
      directed.push_back('{make_tri(0,0,0, 0,1,0, 1,0,0), 1, make_normal(0,0,-16384,0)});
      directed.push_back('{make_tri(0,0,0, 0,1,0, 0,0,1), 1, make_normal(16384,0,0,0)});
      directed.push_back('{make_tri(0,0,0, 0,0,1, 1,0,0), 1, make_normal(0,16384,0,0)});
      directed.push_back('{make_tri(0,0,0, 0,0,1, 0,1,0), 1, make_normal(-16384,0,0,0)});
      directed.push_back('{make_tri(-32768,-32768,0, 32767,-32768,0, -32768,32767,0),
                           1, make_normal(0,0,16384,0)});
      directed.push_back('{make_tri(32767,32767,32767, -32768,-32768,-32768,
                                    32767,-32768,32767), 0, '0});
      directed.push_back('{make_tri(-32768,32767,-32768, 32767,-32768,32767,
                                    32767,32767,-32768), 0, '0});
      directed.push_back('{make_tri(0,0,0, 1,0,0, 1,1,0), 0, '0});
      directed.push_back('{make_tri(0,0,0, 1,0,0, 0,1,1), 0, '0});
      directed.push_back('{make_tri(0,0,0, 1,0,0, 0,1,2), 0, '0});
      directed.push_back('{make_tri(1,2,3, 4,5,6, 7,8,10), 0, '0});
      directed.push_back('{make_tri(-1,-1,-1, -1,-1,-1, 0,0,0), 1, make_normal(0,0,0,1)});
      directed.push_back('{make_tri(32767,0,0, 0,32767,0, 0,0,32767), 0, '0});
      directed.push_back('{make_tri(-32768,0,0, 0,-32768,0, 0,0,-32768), 0, '0});
      directed.push_back('{make_tri(16'h5555,16'haaaa,16'h5555, 16'haaaa,16'h5555,16'haaaa,
                                    16'h1234,16'hedcb,16'h7f00), 0, '0});

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         row = directed[i];
         send_request(row.corners, row.known, row.answer);
      end

      // Three idling profiles; between them hold off until the pipe is empty.
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 52 : 0;
         recv_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 9 : 0;
         for (int n = 0; n < N_RANDOM / 3; n++) begin
            send_request(rand_tri(), 1'b0, '0);
         end
         req_valid <= 1'b0;
         while (normal_queue.size() != 0) @(posedge clock);
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (normal_queue.size() != 0) begin
         mismatches++;
         $display("%0d expected responses never arrived", normal_queue.size());
      end
      $display("Covered %0d triangles (%0d degenerate) over three idling profiles",
               accepted_reqs, degen_rsps);
      $display("Checked %0d responses, %0d mismatches", checked_rsps, mismatches);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule : testbench

`default_nettype wire
